FILE: src/jsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes of the JSON string unescape / UTF-8 core.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int JSU_QUEUE_DEPTH = 4;

    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_NOQUOTE = 3'd1;
    localparam logic [2:0] ERR_RAW     = 3'd2;
    localparam logic [2:0] ERR_ESC     = 3'd3;
    localparam logic [2:0] ERR_UNI     = 3'd4;
    localparam logic [2:0] ERR_UTF8    = 3'd5;

    // One decoded input byte: up to four result transactions.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic [1:0]      status;
        logic [2:0]      err;
    } t_cmd;

endpackage
`default_nettype wire

FILE: src/jsu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front
// Accepts one text byte per cycle unless stalled, runs the string/escape/UTF-8
// decoder and pushes one result command per byte that produces results.
// ----------------------------------------------------------------------------
module jsu_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [7:0]   i_in_byte,
    input  wire logic         i_full,
    output logic              o_push,
    output jsu_pkg::t_cmd     o_cmd
);
    import jsu_pkg::*;

    localparam logic [2:0] M_IDLE     = 3'd0;
    localparam logic [2:0] M_BODY     = 3'd1;
    localparam logic [2:0] M_ESC      = 3'd2;
    localparam logic [2:0] M_HEX1     = 3'd3;
    localparam logic [2:0] M_NEED_BSL = 3'd4;
    localparam logic [2:0] M_NEED_U   = 3'd5;
    localparam logic [2:0] M_HEX2     = 3'd6;

    localparam logic [2:0] R_ANY = 3'd0;
    localparam logic [2:0] R_A0  = 3'd1;
    localparam logic [2:0] R_9F  = 3'd2;
    localparam logic [2:0] R_90  = 3'd3;
    localparam logic [2:0] R_8F  = 3'd4;

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_hs, n_hs;
    logic [1:0]  r_pend, n_pend;
    logic [2:0]  r_rule, n_rule;

    logic        w_accept;
    logic        w_u_ok;
    logic [1:0]  w_u_pend;
    logic [2:0]  w_u_rule;
    logic        w_hex_ok;
    logic [3:0]  w_hex_val;
    logic [15:0] w_cu;
    logic        w_fail;
    logic [2:0]  w_code;
    logic        w_emit;
    logic [20:0] w_cp;
    logic        w_raw;
    logic        w_done;
    logic        w_has;
    t_cmd        w_cmd;

    function automatic t_cmd f_encode(input logic [20:0] cp);
        t_cmd c;
        c = '0;
        c.status = ST_BYTE;
        c.err    = ERR_NONE;
        if (cp <= 21'h00007F) begin
            c.bytes[0] = cp[7:0];
            c.last_idx = 2'd0;
        end else if (cp <= 21'h0007FF) begin
            c.bytes[0] = {3'b110, cp[10:6]};
            c.bytes[1] = {2'b10, cp[5:0]};
            c.last_idx = 2'd1;
        end else if (cp <= 21'h00FFFF) begin
            c.bytes[0] = {4'b1110, cp[15:12]};
            c.bytes[1] = {2'b10, cp[11:6]};
            c.bytes[2] = {2'b10, cp[5:0]};
            c.last_idx = 2'd2;
        end else begin
            c.bytes[0] = {5'b11110, cp[20:18]};
            c.bytes[1] = {2'b10, cp[17:12]};
            c.bytes[2] = {2'b10, cp[11:6]};
            c.bytes[3] = {2'b10, cp[5:0]};
            c.last_idx = 2'd3;
        end
        return c;
    endfunction

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;

    // strict UTF-8 tracker for raw body bytes
    always_comb begin
        w_u_ok   = 1'b0;
        w_u_pend = r_pend;
        w_u_rule = r_rule;
        if (r_pend != 2'd0) begin
            case (r_rule)
                R_A0:    w_u_ok = (i_in_byte >= 8'hA0) && (i_in_byte <= 8'hBF);
                R_9F:    w_u_ok = (i_in_byte >= 8'h80) && (i_in_byte <= 8'h9F);
                R_90:    w_u_ok = (i_in_byte >= 8'h90) && (i_in_byte <= 8'hBF);
                R_8F:    w_u_ok = (i_in_byte >= 8'h80) && (i_in_byte <= 8'h8F);
                default: w_u_ok = (i_in_byte >= 8'h80) && (i_in_byte <= 8'hBF);
            endcase
            w_u_pend = r_pend - 2'd1;
            w_u_rule = R_ANY;
        end else if (i_in_byte == 8'h00) begin
            w_u_ok = 1'b0;
        end else if (i_in_byte < 8'h80) begin
            w_u_ok = 1'b1;
        end else if (i_in_byte < 8'hC2 || i_in_byte > 8'hF4) begin
            w_u_ok = 1'b0;
        end else if (i_in_byte < 8'hE0) begin
            w_u_ok   = 1'b1;
            w_u_pend = 2'd1;
            w_u_rule = R_ANY;
        end else if (i_in_byte < 8'hF0) begin
            w_u_ok   = 1'b1;
            w_u_pend = 2'd2;
            w_u_rule = (i_in_byte == 8'hE0) ? R_A0 :
                       (i_in_byte == 8'hED) ? R_9F : R_ANY;
        end else begin
            w_u_ok   = 1'b1;
            w_u_pend = 2'd3;
            w_u_rule = (i_in_byte == 8'hF0) ? R_90 :
                       (i_in_byte == 8'hF4) ? R_8F : R_ANY;
        end
    end

    always_comb begin
        w_hex_ok  = 1'b1;
        w_hex_val = 4'd0;
        if (i_in_byte >= "0" && i_in_byte <= "9") begin
            w_hex_val = 4'(i_in_byte - "0");
        end else if (i_in_byte >= "a" && i_in_byte <= "f") begin
            w_hex_val = 4'(i_in_byte - "a" + 8'd10);
        end else if (i_in_byte >= "A" && i_in_byte <= "F") begin
            w_hex_val = 4'(i_in_byte - "A" + 8'd10);
        end else begin
            w_hex_ok = 1'b0;
        end
    end

    assign w_cu = {r_acc[11:0], w_hex_val};

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_hs   = r_hs;
        n_pend = r_pend;
        n_rule = r_rule;
        w_fail = 1'b0;
        w_code = ERR_NONE;
        w_emit = 1'b0;
        w_cp   = '0;
        w_raw  = 1'b0;
        w_done = 1'b0;
        w_has  = 1'b0;
        w_cmd  = '0;

        case (r_mode)
            M_BODY: begin
                if (i_in_byte == 8'h00 || i_in_byte == 8'h09 || i_in_byte == 8'h0A) begin
                    w_fail = 1'b1;
                    w_code = ERR_RAW;
                end else if (i_in_byte == "\"") begin
                    if (r_pend != 2'd0) begin
                        w_fail = 1'b1;
                        w_code = ERR_UTF8;
                    end else begin
                        w_done = 1'b1;
                    end
                end else if (i_in_byte == "\\") begin
                    n_mode = M_ESC;
                end else if (!w_u_ok) begin
                    w_fail = 1'b1;
                    w_code = ERR_UTF8;
                end else begin
                    w_raw  = 1'b1;
                    n_pend = w_u_pend;
                    n_rule = w_u_rule;
                end
            end
            M_ESC: begin
                case (i_in_byte)
                    "\"", "\\", "/": begin
                        w_emit = 1'b1;
                        w_cp   = {13'd0, i_in_byte};
                    end
                    "b": begin
                        w_emit = 1'b1;
                        w_cp   = 21'h08;
                    end
                    "f": begin
                        w_emit = 1'b1;
                        w_cp   = 21'h0C;
                    end
                    "n": begin
                        w_emit = 1'b1;
                        w_cp   = 21'h0A;
                    end
                    "r": begin
                        w_emit = 1'b1;
                        w_cp   = 21'h0D;
                    end
                    "t": begin
                        w_emit = 1'b1;
                        w_cp   = 21'h09;
                    end
                    "u": begin
                        n_mode = M_HEX1;
                        n_acc  = '0;
                        n_cnt  = '0;
                    end
                    default: begin
                        w_fail = 1'b1;
                        w_code = ERR_ESC;
                    end
                endcase
            end
            M_HEX1, M_HEX2: begin
                if (!w_hex_ok) begin
                    w_fail = 1'b1;
                    w_code = ERR_UNI;
                end else if (r_cnt != 2'd3) begin
                    n_acc = w_cu;
                    n_cnt = r_cnt + 2'd1;
                end else begin
                    n_acc = '0;
                    n_cnt = '0;
                    if (r_mode == M_HEX1) begin
                        if (w_cu >= 16'hD800 && w_cu <= 16'hDBFF) begin
                            n_hs   = w_cu[9:0];
                            n_mode = M_NEED_BSL;
                        end else if (w_cu >= 16'hDC00 && w_cu <= 16'hDFFF) begin
                            w_fail = 1'b1;
                            w_code = ERR_UNI;
                        end else begin
                            w_emit = 1'b1;
                            w_cp   = {5'd0, w_cu};
                        end
                    end else begin
                        if (w_cu < 16'hDC00 || w_cu > 16'hDFFF) begin
                            w_fail = 1'b1;
                            w_code = ERR_UNI;
                        end else begin
                            w_emit = 1'b1;
                            w_cp   = 21'h10000 + {1'b0, r_hs, w_cu[9:0]};
                            n_hs   = '0;
                        end
                    end
                end
            end
            M_NEED_BSL: begin
                if (i_in_byte != "\\") begin
                    w_fail = 1'b1;
                    w_code = ERR_UNI;
                end else begin
                    n_mode = M_NEED_U;
                end
            end
            M_NEED_U: begin
                if (i_in_byte != "u") begin
                    w_fail = 1'b1;
                    w_code = ERR_UNI;
                end else begin
                    n_mode = M_HEX2;
                    n_acc  = '0;
                    n_cnt  = '0;
                end
            end
            default: begin
                if (i_in_byte == "\"") begin
                    n_mode = M_BODY;
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_hs   = '0;
                    n_pend = '0;
                    n_rule = R_ANY;
                end else begin
                    w_fail = 1'b1;
                    w_code = ERR_NOQUOTE;
                end
            end
        endcase

        // escape output is refused inside an open sequence and for NUL
        if (w_emit && (r_pend != 2'd0 || w_cp == 21'd0)) begin
            w_emit = 1'b0;
            w_fail = 1'b1;
            w_code = ERR_UTF8;
        end

        if (w_fail || w_done) begin
            n_mode       = w_done ? M_IDLE : M_IDLE;
            n_acc        = '0;
            n_cnt        = '0;
            n_hs         = '0;
            n_pend       = '0;
            n_rule       = R_ANY;
            w_has        = 1'b1;
            w_cmd.status = w_fail ? ST_ERROR : ST_DONE;
            w_cmd.err    = w_fail ? w_code : ERR_NONE;
        end else if (w_emit) begin
            n_mode = M_BODY;
            w_has  = 1'b1;
            w_cmd  = f_encode(w_cp);
        end else if (w_raw) begin
            w_has          = 1'b1;
            w_cmd.bytes[0] = i_in_byte;
            w_cmd.status   = ST_BYTE;
        end
    end

    assign o_push = w_accept && w_has;
    assign o_cmd  = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_hs   <= '0;
            r_pend <= '0;
            r_rule <= R_ANY;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_hs   <= n_hs;
            r_pend <= n_pend;
            r_rule <= n_rule;
        end
    end

endmodule
`default_nettype wire

FILE: src/jsu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_queue
// Small command queue between the decoder front end and the output stage.
// ----------------------------------------------------------------------------
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire jsu_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output jsu_pkg::t_cmd       o_cmd,
    output logic                o_full,
    output logic                o_empty
);
    import jsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count;

    assign n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/jsu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back
// Output stage: expands each queued command into its result transactions,
// one per cycle unless the output is stalled, through a registered output.
// ----------------------------------------------------------------------------
module jsu_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire jsu_pkg::t_cmd  i_cmd,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_run_last,
    output logic [1:0]          o_status,
    output logic [2:0]          o_error_code
);
    import jsu_pkg::*;

    t_cmd       r_cmd;
    logic [1:0] r_idx;
    logic       r_have;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_status;
    logic [2:0] r_err;
    logic       w_adv;
    logic       w_last_cur;
    logic       w_last_new;

    assign w_adv      = !r_valid || !i_stall;
    assign w_last_cur = (r_idx == r_cmd.last_idx);
    assign w_last_new = (i_cmd.last_idx == 2'd0);
    assign o_pop      = w_adv && !r_have && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_have  <= 1'b0;
            r_idx   <= '0;
        end else if (w_adv) begin
            if (r_have) begin
                r_valid <= 1'b1;
                r_have  <= !w_last_cur;
                r_idx   <= r_idx + 2'd1;
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                r_have  <= !w_last_new;
                r_idx   <= 2'd1;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_have) begin
                r_byte   <= r_cmd.bytes[r_idx];
                r_last   <= w_last_cur;
                r_status <= r_cmd.status;
                r_err    <= r_cmd.err;
            end else if (!i_empty) begin
                r_cmd    <= i_cmd;
                r_byte   <= i_cmd.bytes[0];
                r_last   <= w_last_new;
                r_status <= i_cmd.status;
                r_err    <= i_cmd.err;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_byte;
    assign o_run_last   = r_last;
    assign o_status     = r_status;
    assign o_error_code = r_err;

endmodule
`default_nettype wire

FILE: src/json_string_unescape_utf8_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// Streaming JSON string decoder with escape, surrogate and UTF-8 checking.
// ----------------------------------------------------------------------------
// One text byte is accepted per cycle while the input is not stalled. The front
// end decodes it in that cycle and, when it causes any results, queues one
// command holding its 1 to 4 result transactions; the output stage sends those
// one per cycle while the output is not stalled. Input stalls only when the
// command queue (QUEUE_DEPTH entries) is full. A result is registered in the
// queue and then in the output stage before it appears.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core #(
    parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic [1:0]      o_status,
    output logic [2:0]      o_error_code
);
    import jsu_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    jsu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_in_byte (i_in_byte),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_cmd     (w_cmd_in)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd_out),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_status     (o_status),
        .o_error_code (o_error_code)
    );

endmodule
`default_nettype wire
